[rtl/core/osct_pkg.sv]
// Shared constants and types of the order-statistic count tree.
// Field widths, command codes and the default slot capacity.
// No dependencies.
package osct_pkg;

  localparam int unsigned MAX_SLOTS_DEF = 1024;

  localparam int unsigned CMD_W   = 2;
  localparam int unsigned SLOT_W  = 10;
  localparam int unsigned SIZE_W  = 11;
  localparam int unsigned COUNT_W = 11;
  localparam int unsigned RANK_W  = 11;

  typedef enum logic [CMD_W-1:0] {
    CMD_FILL   = 2'd0,
    CMD_SET    = 2'd1,
    CMD_COUNT  = 2'd2,
    CMD_SELECT = 2'd3
  } cmd_t;

endpackage

[rtl/core/order_statistic_count_tree.sv]
// Order-statistic count tree: presence marks per slot with a count tree in one node memory.
// One item is worked at a time, paced by the single read and write port of the node memory.
// Results leave through an output register and a skid.
// Synchronous active-low reset; afterwards a clearing pass writes zero to all 4*MAX_SLOTS nodes,
// one per cycle, and no beat is taken on the input until it ends.
module order_statistic_count_tree #(
  parameter int unsigned MAX_SLOTS = osct_pkg::MAX_SLOTS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // Command channel.
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [osct_pkg::CMD_W-1:0]        in_cmd,
  input  logic [osct_pkg::SLOT_W-1:0]       in_position,
  input  logic                              in_leaf_value,
  input  logic [osct_pkg::SLOT_W-1:0]       in_range_low,
  input  logic [osct_pkg::SLOT_W-1:0]       in_range_high,
  input  logic [osct_pkg::RANK_W-1:0]       in_rank,
  // Result channel.
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [osct_pkg::COUNT_W-1:0]      out_count,
  output logic [osct_pkg::SLOT_W-1:0]       out_found_slot,
  output logic                              out_rank_valid,
  // Size register.
  input  logic                              cfg_wr_en,
  input  logic [osct_pkg::SIZE_W-1:0]       cfg_wr_data
);

  // IW holds a slot index, ADDR_W a node number. Node numbers of any tree shape stay
  // below four times the slot count.
  localparam int unsigned IW       = $clog2(MAX_SLOTS);
  localparam int unsigned DEPTH_N  = 4 * MAX_SLOTS;
  localparam int unsigned ADDR_W   = $clog2(DEPTH_N);
  localparam int unsigned STK_N    = IW + 1;
  localparam int unsigned SPW      = $clog2(STK_N);
  localparam int unsigned EW       = ((IW > osct_pkg::SIZE_W) ? IW : osct_pkg::SIZE_W) + 1;
  localparam int unsigned SIZE_MAX = (2 ** osct_pkg::SIZE_W) - 1;
  localparam int unsigned SIZE_RST = (MAX_SLOTS > SIZE_MAX) ? SIZE_MAX : MAX_SLOTS;
  localparam int unsigned CW       = osct_pkg::COUNT_W;

  typedef enum logic [8:0] {
    ST_CLEAR   = 9'b000000001,
    ST_IDLE    = 9'b000000010,
    ST_FILL    = 9'b000000100,
    ST_SET_DN  = 9'b000001000,
    ST_SET_UP  = 9'b000010000,
    ST_CNT     = 9'b000100000,
    ST_DRAIN   = 9'b001000000,
    ST_SEL_TOT = 9'b010000000,
    ST_SEL_DN  = 9'b100000000
  } state_t;

  // Which side of the range split the count walk is on.
  typedef enum logic [1:0] {
    PH_SPLIT = 2'd0,
    PH_LEFT  = 2'd1,
    PH_RIGHT = 2'd2
  } phase_t;

  // A tree node with the slot interval it covers.
  typedef struct packed {
    logic [ADDR_W-1:0] node;
    logic [IW-1:0]     lo;
    logic [IW-1:0]     hi;
  } frame_t;

  state_t                   state_r, state_nxt;
  phase_t                   phase_r, phase_nxt;
  logic [ADDR_W-1:0]        node_r, node_nxt;
  logic [IW-1:0]            lo_r, lo_nxt;
  logic [IW-1:0]            hi_r, hi_nxt;
  logic [IW-1:0]            x_r, x_nxt;
  logic [IW-1:0]            y_r, y_nxt;
  logic [osct_pkg::RANK_W-1:0] k_r, k_nxt;
  logic [CW-1:0]            val_r, val_nxt;
  logic [CW-1:0]            acc_r, acc_nxt;
  logic                     rv_r, rv_nxt;
  logic [SPW-1:0]           sp_r, sp_nxt;
  frame_t                   sav_r, sav_nxt;
  logic [ADDR_W-1:0]        clr_addr_r, clr_addr_nxt;
  logic                     cap_r, cap_nxt;
  logic [osct_pkg::SIZE_W-1:0] size_in_use_r;

  // Walk stacks: frames for the fill traversal, sibling counts for the set walk.
  frame_t                   frm_stk [STK_N];
  logic [CW-1:0]            sib_stk [STK_N];
  logic                     frm_push;
  frame_t                   frm_push_val;
  logic                     sib_push;
  logic [SPW-1:0]           sp_m1;

  // Node memory port.
  logic                     mem_we;
  logic [ADDR_W-1:0]        mem_waddr;
  logic [CW-1:0]            mem_wdata;
  logic [ADDR_W-1:0]        mem_raddr;
  logic [CW-1:0]            mem_rdata;

  // Result hand-off.
  logic                     fin;
  logic [CW-1:0]            res_cnt;
  logic [osct_pkg::SLOT_W-1:0] res_slot;
  logic                     res_rv;
  logic                     out_valid_r;
  logic [CW-1:0]            out_count_r;
  logic [osct_pkg::SLOT_W-1:0] out_slot_r;
  logic                     out_rv_r;
  logic                     pend_valid_r;
  logic [CW-1:0]            pend_count_r;
  logic [osct_pkg::SLOT_W-1:0] pend_slot_r;
  logic                     pend_rv_r;
  logic                     out_free;

  // Walk arithmetic.
  logic                     in_acc;
  logic [EW-1:0]            size_e, n_e, last_e, pos_e, rlo_e, rhi_e, rhic_e;
  logic [IW-1:0]            last_i;
  logic [IW:0]              mid_sum;
  logic [IW-1:0]            mid, mid_p1;
  logic [IW:0]              span;
  logic [ADDR_W-1:0]        left_node, right_node;
  logic                     go_left;
  logic [ADDR_W-1:0]        c_node;
  logic [IW-1:0]            c_lo, c_hi;
  logic [CW-1:0]            up_sum;

  osct_node_ram #(
    .DEPTH  (DEPTH_N),
    .ADDR_W (ADDR_W)
  ) u_node_ram (
    .clk     (clk),
    .wr_en   (mem_we),
    .wr_addr (mem_waddr),
    .wr_data (mem_wdata),
    .rd_addr (mem_raddr),
    .rd_data (mem_rdata)
  );

  // A size of zero acts as one slot and anything beyond the capacity is cut to it.
  always_comb begin
    size_e = EW'(size_in_use_r);
    if (size_e == '0) begin
      n_e = EW'(1);
    end else if (size_e > EW'(MAX_SLOTS)) begin
      n_e = EW'(MAX_SLOTS);
    end else begin
      n_e = size_e;
    end
    last_e = n_e - EW'(1);
    last_i = IW'(last_e);
    pos_e  = EW'(in_position);
    rlo_e  = EW'(in_range_low);
    rhi_e  = EW'(in_range_high);
    rhic_e = (rhi_e > last_e) ? last_e : rhi_e;
  end

  assign in_stall   = (state_r != ST_IDLE) || pend_valid_r;
  assign in_acc     = in_valid && !in_stall;
  assign mid_sum    = {1'b0, lo_r} + {1'b0, hi_r};
  assign mid        = mid_sum[IW:1];
  assign mid_p1     = mid + IW'(1);
  assign span       = {1'b0, hi_r} - {1'b0, lo_r} + (IW + 1)'(1);
  assign left_node  = {node_r[ADDR_W-2:0], 1'b0};
  assign right_node = {node_r[ADDR_W-2:0], 1'b1};
  assign sp_m1      = sp_r - SPW'(1);
  assign up_sum     = val_r + sib_stk[sp_m1];

  // Select step: the left child count sits on the read port this cycle.
  always_comb begin
    go_left = (mem_rdata >= k_r);
    if (go_left) begin
      c_node = left_node;
      c_lo   = lo_r;
      c_hi   = mid;
    end else begin
      c_node = right_node;
      c_lo   = mid_p1;
      c_hi   = hi_r;
    end
  end

  always_comb begin
    state_nxt    = state_r;
    phase_nxt    = phase_r;
    node_nxt     = node_r;
    lo_nxt       = lo_r;
    hi_nxt       = hi_r;
    x_nxt        = x_r;
    y_nxt        = y_r;
    k_nxt        = k_r;
    val_nxt      = val_r;
    acc_nxt      = acc_r;
    rv_nxt       = rv_r;
    sp_nxt       = sp_r;
    sav_nxt      = sav_r;
    clr_addr_nxt = clr_addr_r;
    cap_nxt      = 1'b0;
    mem_we       = 1'b0;
    mem_waddr    = node_r;
    mem_wdata    = '0;
    mem_raddr    = ADDR_W'(1);
    frm_push     = 1'b0;
    frm_push_val.node = right_node;
    frm_push_val.lo   = mid_p1;
    frm_push_val.hi   = hi_r;
    sib_push     = 1'b0;
    fin          = 1'b0;
    res_cnt      = '0;
    res_slot     = '0;
    res_rv       = 1'b0;

    // A read issued last cycle has its data now: the set walk stacks it as a sibling
    // count, the count walk adds it up.
    if (cap_r) begin
      if (state_r == ST_SET_DN) begin
        sib_push = 1'b1;
        sp_nxt   = sp_r + SPW'(1);
      end else begin
        acc_nxt = acc_r + mem_rdata;
      end
    end

    unique case (state_r)
      ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_addr_r;
        if (clr_addr_r == ADDR_W'(DEPTH_N - 1)) begin
          state_nxt = ST_IDLE;
        end else begin
          clr_addr_nxt = clr_addr_r + ADDR_W'(1);
        end
      end

      ST_IDLE: begin
        // The root is read every idle cycle so a select finds the total at once.
        if (in_acc) begin
          node_nxt  = ADDR_W'(1);
          lo_nxt    = '0;
          hi_nxt    = last_i;
          sp_nxt    = '0;
          acc_nxt   = '0;
          phase_nxt = PH_SPLIT;
          k_nxt     = in_rank;
          val_nxt   = CW'(in_leaf_value);
          unique case (osct_pkg::cmd_t'(in_cmd))
            osct_pkg::CMD_FILL: begin
              state_nxt = ST_FILL;
            end
            osct_pkg::CMD_SET: begin
              if (pos_e < n_e) begin
                x_nxt     = IW'(pos_e);
                state_nxt = ST_SET_DN;
              end else begin
                fin = 1'b1;
              end
            end
            osct_pkg::CMD_COUNT: begin
              if (rlo_e <= rhic_e) begin
                x_nxt     = IW'(rlo_e);
                y_nxt     = IW'(rhic_e);
                state_nxt = ST_CNT;
              end else begin
                fin = 1'b1;
              end
            end
            osct_pkg::CMD_SELECT: begin
              state_nxt = ST_SEL_TOT;
            end
            default: begin
              state_nxt = ST_IDLE;
            end
          endcase
        end
      end

      ST_FILL: begin
        // Depth-first over the shape; every node gets the width of its interval.
        mem_we    = 1'b1;
        mem_wdata = CW'(span);
        if (lo_r != hi_r) begin
          frm_push = 1'b1;
          sp_nxt   = sp_r + SPW'(1);
          node_nxt = left_node;
          hi_nxt   = mid;
        end else if (sp_r == '0) begin
          fin       = 1'b1;
          state_nxt = ST_IDLE;
        end else begin
          node_nxt = frm_stk[sp_m1].node;
          lo_nxt   = frm_stk[sp_m1].lo;
          hi_nxt   = frm_stk[sp_m1].hi;
          sp_nxt   = sp_m1;
        end
      end

      ST_SET_DN: begin
        if (lo_r != hi_r) begin
          cap_nxt = 1'b1;
          if (x_r <= mid) begin
            mem_raddr = right_node;
            node_nxt  = left_node;
            hi_nxt    = mid;
          end else begin
            mem_raddr = left_node;
            node_nxt  = right_node;
            lo_nxt    = mid_p1;
          end
        end else begin
          mem_we    = 1'b1;
          mem_wdata = val_r;
          state_nxt = ST_SET_UP;
        end
      end

      ST_SET_UP: begin
        if (sp_r == '0) begin
          fin       = 1'b1;
          state_nxt = ST_IDLE;
        end else begin
          mem_we    = 1'b1;
          mem_waddr = node_r >> 1;
          mem_wdata = up_sum;
          node_nxt  = node_r >> 1;
          val_nxt   = up_sum;
          sp_nxt    = sp_m1;
        end
      end

      ST_CNT: begin
        // The walk splits once; after that the left path runs toward the low end and
        // the right path toward the high end, adding the fully covered subtrees.
        unique case (phase_r)
          PH_SPLIT: begin
            if (lo_r >= x_r && hi_r <= y_r) begin
              mem_raddr = node_r;
              cap_nxt   = 1'b1;
              state_nxt = ST_DRAIN;
            end else if (y_r <= mid) begin
              node_nxt = left_node;
              hi_nxt   = mid;
            end else if (x_r > mid) begin
              node_nxt = right_node;
              lo_nxt   = mid_p1;
            end else begin
              sav_nxt.node = right_node;
              sav_nxt.lo   = mid_p1;
              sav_nxt.hi   = hi_r;
              node_nxt     = left_node;
              hi_nxt       = mid;
              phase_nxt    = PH_LEFT;
            end
          end
          PH_LEFT: begin
            if (lo_r >= x_r) begin
              mem_raddr = node_r;
              cap_nxt   = 1'b1;
              node_nxt  = sav_r.node;
              lo_nxt    = sav_r.lo;
              hi_nxt    = sav_r.hi;
              phase_nxt = PH_RIGHT;
            end else if (x_r <= mid) begin
              mem_raddr = right_node;
              cap_nxt   = 1'b1;
              node_nxt  = left_node;
              hi_nxt    = mid;
            end else begin
              node_nxt = right_node;
              lo_nxt   = mid_p1;
            end
          end
          PH_RIGHT: begin
            if (hi_r <= y_r) begin
              mem_raddr = node_r;
              cap_nxt   = 1'b1;
              state_nxt = ST_DRAIN;
            end else if (y_r > mid) begin
              mem_raddr = left_node;
              cap_nxt   = 1'b1;
              node_nxt  = right_node;
              lo_nxt    = mid_p1;
            end else begin
              node_nxt = left_node;
              hi_nxt   = mid;
            end
          end
          default: begin
            state_nxt = ST_IDLE;
          end
        endcase
      end

      ST_DRAIN: begin
        fin       = 1'b1;
        res_cnt   = acc_nxt;
        state_nxt = ST_IDLE;
      end

      ST_SEL_TOT: begin
        rv_nxt = (k_r != '0) && (k_r <= mem_rdata);
        if (lo_r == hi_r) begin
          fin       = 1'b1;
          res_slot  = osct_pkg::SLOT_W'(lo_r);
          res_rv    = rv_nxt;
          state_nxt = ST_IDLE;
        end else begin
          mem_raddr = left_node;
          state_nxt = ST_SEL_DN;
        end
      end

      ST_SEL_DN: begin
        node_nxt = c_node;
        lo_nxt   = c_lo;
        hi_nxt   = c_hi;
        if (!go_left) begin
          k_nxt = k_r - mem_rdata;
        end
        if (c_lo == c_hi) begin
          fin       = 1'b1;
          res_slot  = osct_pkg::SLOT_W'(c_lo);
          res_rv    = rv_r;
          state_nxt = ST_IDLE;
        end else begin
          mem_raddr = {c_node[ADDR_W-2:0], 1'b0};
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_CLEAR;
      clr_addr_r    <= '0;
      cap_r         <= 1'b0;
      sp_r          <= '0;
      phase_r       <= PH_SPLIT;
      size_in_use_r <= osct_pkg::SIZE_W'(SIZE_RST);
    end else begin
      state_r    <= state_nxt;
      clr_addr_r <= clr_addr_nxt;
      cap_r      <= cap_nxt;
      sp_r       <= sp_nxt;
      phase_r    <= phase_nxt;
      if (cfg_wr_en) begin
        size_in_use_r <= cfg_wr_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    node_r <= node_nxt;
    lo_r   <= lo_nxt;
    hi_r   <= hi_nxt;
    x_r    <= x_nxt;
    y_r    <= y_nxt;
    k_r    <= k_nxt;
    val_r  <= val_nxt;
    acc_r  <= acc_nxt;
    rv_r   <= rv_nxt;
    sav_r  <= sav_nxt;
    if (frm_push) begin
      frm_stk[sp_r] <= frm_push_val;
    end
    if (sib_push) begin
      sib_stk[sp_r] <= mem_rdata;
    end
  end

  // Output register with a one-beat skid behind it. Intake stalls while the skid is
  // full, so a finished command always finds a free place.
  assign out_free = !out_valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      pend_valid_r <= 1'b0;
    end else begin
      if (pend_valid_r && out_free) begin
        out_valid_r  <= 1'b1;
        pend_valid_r <= 1'b0;
      end else if (fin) begin
        if (out_free) begin
          out_valid_r <= 1'b1;
        end else begin
          pend_valid_r <= 1'b1;
        end
      end else if (out_free) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pend_valid_r && out_free) begin
      out_count_r <= pend_count_r;
      out_slot_r  <= pend_slot_r;
      out_rv_r    <= pend_rv_r;
    end else if (fin && out_free) begin
      out_count_r <= res_cnt;
      out_slot_r  <= res_slot;
      out_rv_r    <= res_rv;
    end
    if (fin && !out_free) begin
      pend_count_r <= res_cnt;
      pend_slot_r  <= res_slot;
      pend_rv_r    <= res_rv;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_count      = out_count_r;
  assign out_found_slot = out_slot_r;
  assign out_rank_valid = out_rv_r;

  // A command must never finish while the skid still holds an older result.
  a_fin_skid_free: assert property (@(posedge clk) disable iff (!rst_n)
    fin |-> !pend_valid_r)
    else $error("result finished while skid register was occupied");

  // Read data is only ever expected by the set and count walks.
  a_cap_owner: assert property (@(posedge clk) disable iff (!rst_n)
    cap_r |-> (state_r == ST_SET_DN || state_r == ST_CNT || state_r == ST_DRAIN))
    else $error("node read returned outside a walk that consumes it");

  // The walk stacks never grow beyond the tree height.
  a_stack_depth: assert property (@(posedge clk) disable iff (!rst_n)
    sp_r <= SPW'(IW))
    else $error("walk stack pointer exceeded tree height");

endmodule

[rtl/core/osct_node_ram.sv]
// Node count store of the order-statistic count tree: one write port, one read port.
// Read data is registered, so it appears in the cycle after the address is given.
// Depends on osct_pkg for the count width and the default depth.
module osct_node_ram #(
  parameter int unsigned DEPTH  = 4 * osct_pkg::MAX_SLOTS_DEF,
  parameter int unsigned ADDR_W = $clog2(DEPTH)
) (
  input  logic                              clk,
  input  logic                              wr_en,
  input  logic [ADDR_W-1:0]                 wr_addr,
  input  logic [osct_pkg::COUNT_W-1:0]      wr_data,
  input  logic [ADDR_W-1:0]                 rd_addr,
  output logic [osct_pkg::COUNT_W-1:0]      rd_data
);

  logic [osct_pkg::COUNT_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

[dv/count_tree_sb_pkg.sv]
// Scoreboard for the order-statistic count tree: a predictor of the node store and
// a queue of expected result beats. Depends on osct_pkg for widths and command codes.
package count_tree_sb_pkg;
  import osct_pkg::*;

  localparam int unsigned NODE_TOTAL = 4 * MAX_SLOTS_DEF;
  localparam int unsigned PRINT_CAP  = 40;
  // Room for the tree walks below; a walk of a 1024-slot tree needs about a dozen.
  localparam int unsigned WALK_STACK = 64;

  typedef struct {
    cmd_t              cmd;
    logic [SLOT_W-1:0] position;
    logic              leaf_value;
    logic [SLOT_W-1:0] range_low;
    logic [SLOT_W-1:0] range_high;
    logic [RANK_W-1:0] rank;
  } tree_cmd_t;

  typedef struct {
    logic [COUNT_W-1:0] count;
    logic [SLOT_W-1:0]  found_slot;
    logic               rank_valid;
  } tree_result_t;

  class count_tree_scoreboard;
    logic [COUNT_W-1:0] node_cnt [NODE_TOTAL];
    logic [SIZE_W-1:0]  size_reg;
    tree_result_t       pending_results [$];
    int unsigned        cmds_seen [4];
    int unsigned        results_checked;
    int unsigned        mismatches;

    function new();
      foreach (node_cnt[i]) node_cnt[i] = '0;
      foreach (cmds_seen[i]) cmds_seen[i] = 0;
      size_reg        = SIZE_W'(MAX_SLOTS_DEF);
      results_checked = 0;
      mismatches      = 0;
    endfunction

    function int unsigned node_at(int unsigned idx);
      return (idx < NODE_TOTAL) ? int'(node_cnt[idx]) : 0;
    endfunction

    function void put_node(int unsigned idx, int unsigned v);
      if (idx < NODE_TOTAL) node_cnt[idx] = COUNT_W'(v);
    endfunction

    // A size of zero behaves as one slot, anything above capacity as full capacity.
    function int unsigned slots_in_use();
      if (size_reg == 0) return 1;
      if (size_reg > MAX_SLOTS_DEF) return MAX_SLOTS_DEF;
      return int'(size_reg);
    endfunction

    // After a fill every node of the current shape holds the width of its span.
    function void fill_all(int unsigned n);
      int unsigned st_node [WALK_STACK];
      int unsigned st_lo [WALK_STACK];
      int unsigned st_hi [WALK_STACK];
      int unsigned top, nd, l, r, mid;
      st_node[0] = 1;
      st_lo[0]   = 0;
      st_hi[0]   = n - 1;
      top        = 1;
      while (top != 0) begin
        top--;
        nd = st_node[top];
        l  = st_lo[top];
        r  = st_hi[top];
        put_node(nd, r - l + 1);
        if (l != r) begin
          mid              = (l + r) >> 1;
          st_node[top]     = 2 * nd;
          st_lo[top]       = l;
          st_hi[top]       = mid;
          st_node[top + 1] = 2 * nd + 1;
          st_lo[top + 1]   = mid + 1;
          st_hi[top + 1]   = r;
          top += 2;
        end
      end
    endfunction

    function void set_mark(int unsigned n, int unsigned pos, int unsigned v);
      int unsigned path [WALK_STACK];
      int unsigned depth, nd, l, r, mid;
      depth = 0;
      nd    = 1;
      l     = 0;
      r     = n - 1;
      while (l != r) begin
        path[depth] = nd;
        depth++;
        mid = (l + r) >> 1;
        if (pos <= mid) begin
          nd = 2 * nd;
          r  = mid;
        end else begin
          nd = 2 * nd + 1;
          l  = mid + 1;
        end
      end
      put_node(nd, v);
      while (depth != 0) begin
        depth--;
        nd = path[depth];
        put_node(nd, node_at(2 * nd) + node_at(2 * nd + 1));
      end
    endfunction

    function logic [COUNT_W-1:0] range_count(int unsigned n, int unsigned x, int unsigned y);
      int unsigned st_node [WALK_STACK];
      int unsigned st_lo [WALK_STACK];
      int unsigned st_hi [WALK_STACK];
      int unsigned top, nd, l, r, mid, sum;
      sum        = 0;
      st_node[0] = 1;
      st_lo[0]   = 0;
      st_hi[0]   = n - 1;
      top        = 1;
      while (top != 0) begin
        top--;
        nd = st_node[top];
        l  = st_lo[top];
        r  = st_hi[top];
        if (l > y || r < x) begin
          // Span lies outside the range.
        end else if (l >= x && r <= y) begin
          sum += node_at(nd);
        end else begin
          mid              = (l + r) >> 1;
          st_node[top]     = 2 * nd;
          st_lo[top]       = l;
          st_hi[top]       = mid;
          st_node[top + 1] = 2 * nd + 1;
          st_lo[top + 1]   = mid + 1;
          st_hi[top + 1]   = r;
          top += 2;
        end
      end
      return COUNT_W'(sum);
    endfunction

    // The walk never fails: an out-of-range rank still lands on some slot.
    function int unsigned select_rank(int unsigned n, int k);
      int unsigned nd, l, r, mid;
      int left;
      nd = 1;
      l  = 0;
      r  = n - 1;
      while (l != r) begin
        left = int'(node_at(2 * nd));
        mid  = (l + r) >> 1;
        if (left >= k) begin
          nd = 2 * nd;
          r  = mid;
        end else begin
          k -= left;
          nd = 2 * nd + 1;
          l  = mid + 1;
        end
      end
      return l;
    endfunction

    function void note_command(tree_cmd_t c);
      tree_result_t want;
      int unsigned  n, hi;
      n               = slots_in_use();
      want.count      = '0;
      want.found_slot = '0;
      want.rank_valid = 1'b0;
      cmds_seen[c.cmd]++;
      case (c.cmd)
        CMD_FILL: fill_all(n);
        CMD_SET: begin
          if (c.position < n) set_mark(n, c.position, c.leaf_value);
        end
        CMD_COUNT: begin
          hi = c.range_high;
          if (hi > n - 1) hi = n - 1;
          if (c.range_low <= hi) want.count = range_count(n, c.range_low, hi);
        end
        CMD_SELECT: begin
          want.found_slot = SLOT_W'(select_rank(n, int'(c.rank)));
          want.rank_valid = (c.rank >= 1) && (c.rank <= node_at(1));
        end
      endcase
      pending_results = {pending_results, want};
    endfunction

    task report_mismatch(string what);
      if (mismatches < PRINT_CAP) $display("MISMATCH at %0t: %s", $time, what);
      mismatches++;
    endtask

    task check_result(logic [COUNT_W-1:0] count, logic [SLOT_W-1:0] slot, logic rank_valid);
      tree_result_t want;
      results_checked++;
      if (pending_results.size() == 0) begin
        report_mismatch($sformatf("result beat with nothing expected: count %0d slot %0d valid %0b",
                                  count, slot, rank_valid));
        return;
      end
      want = pending_results.pop_front();
      if (count !== want.count || slot !== want.found_slot || rank_valid !== want.rank_valid)
        report_mismatch($sformatf("result %0d: got count %0d slot %0d valid %0b, want %0d %0d %0b",
                                  results_checked, count, slot, rank_valid,
                                  want.count, want.found_slot, want.rank_valid));
    endtask
  endclass

endpackage

[dv/tb.sv]
// Top-level testbench of the order-statistic count tree: drives commands and size
// writes, checks every result beat. Depends on osct_pkg and count_tree_sb_pkg.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import osct_pkg::*;
  import count_tree_sb_pkg::*;

  // A long receiver hold-off fills the output register and skid and then backs up
  // the command channel. The watchdog limit covers the clearing pass after reset
  // and a full-size fill several times over.
  localparam int unsigned HOLD_OFF_CYCLES = 300;
  localparam int unsigned STUCK_LIMIT     = 20000;
  localparam int unsigned DRAIN_CYCLES    = 64;

  // Size settings of the random part. Zero and everything above 1024 are the
  // clamped cases; phases with an even index start without a fill, so the walks
  // run over whatever the previous shape left in the node store.
  localparam int unsigned PHASES = 13;
  localparam int unsigned PHASE_SIZE [PHASES] =
    '{0, 1, 2, 1025, 7, 2047, 37, 3, 100, 1024, 16, 513, 5};
  localparam int unsigned PHASE_LEN [PHASES] =
    '{20, 25, 30, 20, 50, 20, 60, 40, 70, 25, 60, 40, 40};
  localparam int unsigned HOLD_OFF_PHASE = 6;

  logic                clk;
  logic                rst_n;
  logic                in_valid;
  logic                in_stall;
  logic [CMD_W-1:0]    in_cmd;
  logic [SLOT_W-1:0]   in_position;
  logic                in_leaf_value;
  logic [SLOT_W-1:0]   in_range_low;
  logic [SLOT_W-1:0]   in_range_high;
  logic [RANK_W-1:0]   in_rank;
  logic                out_valid;
  logic                out_stall;
  logic [COUNT_W-1:0]  out_count;
  logic [SLOT_W-1:0]   out_found_slot;
  logic                out_rank_valid;
  logic                cfg_wr_en;
  logic [SIZE_W-1:0]   cfg_wr_data;

  // Idle rates in percent per cycle; the main sequence moves them through the
  // three idling regimes.
  int unsigned send_idle_pct = 27;
  int unsigned recv_idle_pct = 55;
  bit          hold_off_go   = 1'b0;
  int unsigned sizes_tried   = 0;

  count_tree_scoreboard tree_sb;

  order_statistic_count_tree dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_cmd        (in_cmd),
    .in_position   (in_position),
    .in_leaf_value (in_leaf_value),
    .in_range_low  (in_range_low),
    .in_range_high (in_range_high),
    .in_rank       (in_rank),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_count     (out_count),
    .out_found_slot(out_found_slot),
    .out_rank_valid(out_rank_valid),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Receiver: one stall decision per falling edge. When a hold-off is requested
  // the stall stays high for a fixed stretch, counted here, while the sender keeps
  // offering commands.
  initial begin
    forever begin
      if (hold_off_go) begin
        hold_off_go = 1'b0;
        for (int i = 0; i < HOLD_OFF_CYCLES; i++) begin
          out_stall <= 1'b1;
          @(negedge clk);
        end
      end else begin
        out_stall <= ($urandom_range(99) < recv_idle_pct);
        @(negedge clk);
      end
    end
  end

  // Result beats are checked at the rising edge at which they are taken.
  always @(posedge clk) begin
    if (rst_n && out_valid === 1'b1 && !out_stall)
      tree_sb.check_result(out_count, out_found_slot, out_rank_valid);
  end

  // The watchdog ends the run after a long stretch in which no beat moves on
  // either channel.
  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < STUCK_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_stall === 1'b0) || (out_valid === 1'b1 && !out_stall))
        quiet = 0;
      else
        quiet++;
    end
    $display("Watchdog: %0d cycles without an accepted beat", STUCK_LIMIT);
    $display("Verification failed");
    $finish;
  end

  function automatic tree_cmd_t make_cmd(cmd_t cmd, int unsigned pos, bit val,
                                         int unsigned lo, int unsigned hi, int unsigned rank);
    tree_cmd_t c;
    c.cmd        = cmd;
    c.position   = SLOT_W'(pos);
    c.leaf_value = val;
    c.range_low  = SLOT_W'(lo);
    c.range_high = SLOT_W'(hi);
    c.rank       = RANK_W'(rank);
    return c;
  endfunction

  // Fields a command does not use carry random noise. Most positions, ranges and
  // ranks land inside the current shape and the current total so that the walks
  // see real content; the rest exercise clamping and out-of-range ranks.
  function automatic tree_cmd_t random_command(int unsigned n, int unsigned total);
    tree_cmd_t   c;
    int unsigned pick;
    c.cmd        = CMD_SELECT;
    c.position   = SLOT_W'($urandom);
    c.leaf_value = 1'($urandom);
    c.range_low  = SLOT_W'($urandom);
    c.range_high = SLOT_W'($urandom);
    c.rank       = RANK_W'($urandom_range(MAX_SLOTS_DEF));
    pick         = $urandom_range(99);
    if (pick < ((n > 256) ? 2 : 8)) begin
      c.cmd = CMD_FILL;
    end else if (pick < 45) begin
      c.cmd = CMD_SET;
      if ($urandom_range(9) != 0) c.position = SLOT_W'($urandom_range(n - 1));
    end else if (pick < 72) begin
      c.cmd = CMD_COUNT;
      if ($urandom_range(4) != 0) begin
        c.range_low  = SLOT_W'($urandom_range(n - 1));
        c.range_high = SLOT_W'($urandom_range(n - 1, c.range_low));
      end
    end else begin
      case ($urandom_range(9))
        0: c.rank = '0;
        1: ;
        2: c.rank = RANK_W'((total + 3 > MAX_SLOTS_DEF) ? MAX_SLOTS_DEF
                            : total + 1 + $urandom_range(2));
        default: c.rank = RANK_W'((total == 0) ? $urandom_range(3, 1)
                                  : $urandom_range(total, 1));
      endcase
    end
    return c;
  endfunction

  // Called at a falling edge; returns at the falling edge after the beat is taken.
  task automatic send_command(tree_cmd_t c);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid      <= 1'b1;
    in_cmd        <= c.cmd;
    in_position   <= c.position;
    in_leaf_value <= c.leaf_value;
    in_range_low  <= c.range_low;
    in_range_high <= c.range_high;
    in_rank       <= c.rank;
    do @(posedge clk); while (in_stall !== 1'b0);
    tree_sb.note_command(c);
    @(negedge clk);
  endtask

  // Every command produces exactly one result, so the block is idle once the
  // expectation queue is empty.
  task automatic drain_results();
    in_valid <= 1'b0;
    while (tree_sb.pending_results.size() != 0) @(negedge clk);
  endtask

  task automatic write_size(int unsigned v);
    @(negedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= SIZE_W'(v);
    @(negedge clk);
    cfg_wr_en        <= 1'b0;
    tree_sb.size_reg = SIZE_W'(v);
    sizes_tried++;
  endtask

  initial begin
    int unsigned random_sent;
    tree_sb       = new();
    random_sent   = 0;
    rst_n         = 1'b0;
    in_valid      = 1'b0;
    in_cmd        = CMD_FILL;
    in_position   = '0;
    in_leaf_value = 1'b0;
    in_range_low  = '0;
    in_range_high = '0;
    in_rank       = '0;
    cfg_wr_en     = 1'b0;
    cfg_wr_data   = '0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed part at the reset size of 1024 slots: the empty store first, then a
    // full store, the ends of the slot range, an empty range, rank zero, the largest
    // rank and a rank above the total.
    send_command(make_cmd(CMD_COUNT, 0, 1'b0, 0, 1023, 0));
    send_command(make_cmd(CMD_SELECT, 0, 1'b0, 0, 0, 1));
    send_command(make_cmd(CMD_FILL, 0, 1'b0, 0, 0, 0));
    send_command(make_cmd(CMD_COUNT, 1023, 1'b1, 0, 1023, 0));
    send_command(make_cmd(CMD_SELECT, 0, 1'b0, 0, 0, 1024));
    send_command(make_cmd(CMD_SELECT, 0, 1'b0, 0, 0, 0));
    send_command(make_cmd(CMD_SELECT, 0, 1'b0, 0, 0, 1));
    send_command(make_cmd(CMD_SET, 1023, 1'b0, 0, 0, 0));
    send_command(make_cmd(CMD_SET, 0, 1'b0, 0, 0, 0));
    send_command(make_cmd(CMD_COUNT, 0, 1'b0, 0, 1023, 0));
    send_command(make_cmd(CMD_COUNT, 0, 1'b0, 5, 3, 0));
    send_command(make_cmd(CMD_COUNT, 0, 1'b0, 1023, 1023, 0));
    send_command(make_cmd(CMD_SELECT, 0, 1'b0, 0, 0, 1023));
    send_command(make_cmd(CMD_SET, 512, 1'b1, 0, 0, 0));
    send_command(make_cmd(CMD_SELECT, 0, 1'b0, 0, 0, 512));

    // Shrink to 16 slots without a fill: the first walks read stale nodes. Then
    // sets beyond the size are ignored and count ranges are cut at the last slot.
    drain_results();
    write_size(16);
    send_command(make_cmd(CMD_COUNT, 0, 1'b0, 0, 1023, 0));
    send_command(make_cmd(CMD_SELECT, 0, 1'b0, 0, 0, 5));
    send_command(make_cmd(CMD_FILL, 0, 1'b0, 0, 0, 0));
    send_command(make_cmd(CMD_SET, 16, 1'b0, 0, 0, 0));
    send_command(make_cmd(CMD_SET, 1023, 1'b0, 0, 0, 0));
    send_command(make_cmd(CMD_COUNT, 0, 1'b0, 10, 1023, 0));
    send_command(make_cmd(CMD_COUNT, 0, 1'b0, 20, 1023, 0));
    send_command(make_cmd(CMD_SELECT, 0, 1'b0, 0, 0, 17));
    send_command(make_cmd(CMD_SET, 3, 1'b0, 0, 0, 0));
    send_command(make_cmd(CMD_SELECT, 0, 1'b0, 0, 0, 3));

    // Random part, one size setting per phase. The size is only written once all
    // results of the previous phase are back, which also pauses the sender until
    // nothing is outstanding.
    for (int p = 0; p < PHASES; p++) begin
      drain_results();
      write_size(PHASE_SIZE[p]);
      if (p == HOLD_OFF_PHASE) hold_off_go = 1'b1;
      for (int k = 0; k < PHASE_LEN[p]; k++) begin
        // Sender idles less than the receiver first, then the reverse, then
        // neither side idles.
        if (random_sent < 167) begin
          send_idle_pct = 27;
          recv_idle_pct = 55;
        end else if (random_sent < 334) begin
          send_idle_pct = 55;
          recv_idle_pct = 27;
        end else begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
        if (k == 0 && (p % 2) == 1)
          send_command(make_cmd(CMD_FILL, $urandom, 1'($urandom), $urandom, $urandom,
                                $urandom_range(MAX_SLOTS_DEF)));
        else
          send_command(random_command(tree_sb.slots_in_use(), tree_sb.node_at(1)));
        random_sent++;
      end
    end

    drain_results();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (tree_sb.pending_results.size() != 0)
      tree_sb.report_mismatch($sformatf("%0d expected results never arrived",
                                        tree_sb.pending_results.size()));

    $display("Covered %0d commands (fill %0d, set %0d, count %0d, select %0d) over %0d sizes.",
             tree_sb.cmds_seen[CMD_FILL] + tree_sb.cmds_seen[CMD_SET] +
             tree_sb.cmds_seen[CMD_COUNT] + tree_sb.cmds_seen[CMD_SELECT],
             tree_sb.cmds_seen[CMD_FILL], tree_sb.cmds_seen[CMD_SET],
             tree_sb.cmds_seen[CMD_COUNT], tree_sb.cmds_seen[CMD_SELECT], sizes_tried);
    $display("Checked %0d result beats, %0d mismatching.",
             tree_sb.results_checked, tree_sb.mismatches);
    if (tree_sb.mismatches == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

endmodule
